FILE: hw/rtl/ctp_pkg.sv
// Shared types and constants of the columnar transposition engine.
// No dependencies; imported by every module of the block except ctp_ram.
`default_nettype none

package ctp_pkg;

    localparam int MSG_DEPTH_DEF     = 128;
    localparam int MAX_ROW_COUNT_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD  = 2'd2;

    // Operating modes; the reserved code behaves as decrypt.
    localparam logic [MODE_W-1:0] MODE_ENC_NOPAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENC_PAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEC       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD      = 2'd3;

    // Input beat kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    // Configuration reset values.
    localparam logic [ROW_W-1:0]  ROWS_RST = 5'd2;
    localparam logic [MODE_W-1:0] MODE_RST = MODE_ENC_PAD;
    localparam logic [BYTE_W-1:0] PAD_RST  = 8'd88;

    typedef struct packed {
        logic [ROW_W-1:0]  rows;
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] pad;
    } t_cfg;

    // Result of one pull, produced at accept time and completed with RAM data.
    typedef struct packed {
        logic              pull;
        logic              valid_res;
        logic              last;
        logic              ovf;
        logic              use_pad;
        logic [BYTE_W-1:0] pad;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/ctp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ctp_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/ctp_div.sv
// Restoring divider, one quotient bit per cycle, used to recount the column
// count and row phase of a loaded message after the row count changes. Uses ctp_pkg.
`default_nettype none

module ctp_div
    import ctp_pkg::*;
#(
    parameter int LW = 8,
    parameter int RW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [LW-1:0] i_dividend,
    input  wire logic [RW-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic      [LW-1:0] o_quot_ceil,
    output logic      [RW-1:0] o_rem
);

    localparam int CW = $clog2(LW + 1);

    logic [LW-1:0] r_dvd;
    logic [LW-1:0] r_q;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_dvd[LW-1]};
        ge    = (trial >= {1'b0, r_dsr});
        diff  = trial - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(LW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[RW-1:0] : trial[RW-1:0];
            r_q   <= {r_q[LW-2:0], ge};
            r_dvd <= {r_dvd[LW-2:0], 1'b0};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quot_ceil = r_q + LW'(r_rem != '0);
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/ctp_ctrl.sv
// Message state, grid address sequencer and message buffer of the engine.
// Uses ctp_pkg, ctp_ram and ctp_div.
`default_nettype none

module ctp_ctrl
    import ctp_pkg::*;
#(
    parameter int MSG_DEPTH     = MSG_DEPTH_DEF,
    parameter int MAX_ROW_COUNT = MAX_ROW_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic              i_kind,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_rows_wr,
    output logic                   o_busy,
    output t_res                   o_res,
    output logic      [BYTE_W-1:0] o_rd_data
);

    localparam int LW = $clog2(MSG_DEPTH + 1);
    localparam int IW = $clog2(MSG_DEPTH);
    localparam int RW = $clog2(MAX_ROW_COUNT + 1);
    localparam int XW = (LW > RW) ? LW : RW;
    localparam int AW = $clog2(MSG_DEPTH + 2 * MAX_ROW_COUNT + 1);

    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_phase, n_phase;
    logic [XW-1:0]     r_outer, n_outer;
    logic [XW-1:0]     r_inner, n_inner;
    logic [AW-1:0]     r_addr, n_addr;
    logic [LW-1:0]     r_emit, n_emit;
    logic              r_drain, n_drain;
    logic              r_ovf, n_ovf;
    logic [XW-1:0]     r_olim, n_olim;
    logic [XW-1:0]     r_ilim, n_ilim;
    logic              r_nopad, n_nopad;
    logic [BYTE_W-1:0] r_pad, n_pad;
    logic              r_div_go;

    logic [RW-1:0]     rows_eff;
    logic              dec_e;
    logic [LW-1:0]     base_len;
    logic [LW-1:0]     base_col;
    logic [RW-1:0]     base_phase;
    logic              base_ovf;
    logic [XW-1:0]     cur_olim, cur_ilim, cur_outer, cur_inner;
    logic [AW-1:0]     cur_addr;
    logic [LW-1:0]     cur_emit, emit1;
    logic              cur_nopad;
    logic [BYTE_W-1:0] cur_pad;
    logic [XW-1:0]     inner1, outer1;
    logic [AW-1:0]     addr_step;
    logic              fin;
    logic              mem_we, mem_re;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    logic              div_busy, div_done;
    logic [LW-1:0]     div_col;
    logic [RW-1:0]     div_rem;

    // Row count as it would be latched: zero acts as one, large values saturate.
    always_comb begin
        if (32'(i_cfg.rows) > MAX_ROW_COUNT) begin
            rows_eff = RW'(MAX_ROW_COUNT);
        end else if (i_cfg.rows == '0) begin
            rows_eff = RW'(1);
        end else begin
            rows_eff = RW'(i_cfg.rows);
        end
        dec_e = i_cfg.mode inside {MODE_DEC, MODE_RSVD};
    end

    always_comb begin
        n_len     = r_len;
        n_col     = r_col;
        n_phase   = r_phase;
        n_outer   = r_outer;
        n_inner   = r_inner;
        n_addr    = r_addr;
        n_emit    = r_emit;
        n_drain   = r_drain;
        n_ovf     = r_ovf;
        n_olim    = r_olim;
        n_ilim    = r_ilim;
        n_nopad   = r_nopad;
        n_pad     = r_pad;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_len[IW-1:0];
        o_res     = '0;

        base_len   = r_drain ? '0 : r_len;
        base_col   = r_drain ? '0 : r_col;
        base_phase = r_drain ? '0 : r_phase;
        base_ovf   = r_drain ? 1'b0 : r_ovf;

        // Position of this pull: a fresh drain starts at the grid origin.
        if (r_drain) begin
            cur_olim  = r_olim;
            cur_ilim  = r_ilim;
            cur_outer = r_outer;
            cur_inner = r_inner;
            cur_addr  = r_addr;
            cur_emit  = r_emit;
            cur_nopad = r_nopad;
            cur_pad   = r_pad;
        end else begin
            cur_olim  = dec_e ? XW'(r_col) : XW'(rows_eff);
            cur_ilim  = dec_e ? XW'(rows_eff) : XW'(r_col);
            cur_outer = '0;
            cur_inner = '0;
            cur_addr  = '0;
            cur_emit  = '0;
            cur_nopad = (i_cfg.mode == MODE_ENC_NOPAD);
            cur_pad   = i_cfg.pad;
        end
        mem_raddr = cur_addr[IW-1:0];
        emit1     = cur_emit + 1'b1;
        inner1    = cur_inner + 1'b1;
        outer1    = cur_outer + 1'b1;
        addr_step = cur_addr + AW'(cur_olim);
        fin = cur_nopad ? (emit1 == r_len)
                        : ((cur_outer == cur_olim - 1'b1) && (cur_inner == cur_ilim - 1'b1));

        if (i_acc && (i_kind == KIND_LOAD)) begin
            // A load during a drain abandons it and starts a new message.
            n_outer = r_drain ? '0 : r_outer;
            n_inner = r_drain ? '0 : r_inner;
            n_addr  = r_drain ? '0 : r_addr;
            n_emit  = r_drain ? '0 : r_emit;
            n_drain = 1'b0;
            n_len   = base_len;
            n_col   = base_col;
            n_phase = base_phase;
            n_ovf   = base_ovf;
            if (base_len < LW'(MSG_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = base_len[IW-1:0];
                n_len     = base_len + 1'b1;
                n_col     = (base_phase == '0) ? base_col + 1'b1 : base_col;
                n_phase   = (base_phase + 1'b1 == rows_eff) ? '0 : base_phase + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end else if (i_acc && (i_kind == KIND_PULL)) begin
            o_res.pull = 1'b1;
            o_res.ovf  = r_ovf;
            if (r_len != '0) begin
                mem_re          = 1'b1;
                o_res.valid_res = 1'b1;
                o_res.last      = fin;
                o_res.use_pad   = (cur_addr >= AW'(r_len));
                o_res.pad       = cur_pad;
                if (fin) begin
                    n_len   = '0;
                    n_col   = '0;
                    n_phase = '0;
                    n_outer = '0;
                    n_inner = '0;
                    n_addr  = '0;
                    n_emit  = '0;
                    n_drain = 1'b0;
                    n_ovf   = 1'b0;
                end else begin
                    n_drain = 1'b1;
                    n_olim  = cur_olim;
                    n_ilim  = cur_ilim;
                    n_nopad = cur_nopad;
                    n_pad   = cur_pad;
                    n_emit  = emit1;
                    if (inner1 == cur_ilim) begin
                        n_inner = '0;
                        n_outer = outer1;
                        n_addr  = AW'(outer1);
                    end else if (cur_nopad && (addr_step >= AW'(r_len))) begin
                        // Only the last column of a row can fall past the message,
                        // so an empty slot means the rest of the row is skipped.
                        n_inner = '0;
                        n_outer = outer1;
                        n_addr  = AW'(outer1);
                    end else begin
                        n_inner = inner1;
                        n_addr  = addr_step;
                    end
                end
            end
        end

        if (div_done) begin
            n_col   = div_col;
            n_phase = div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_col    <= '0;
            r_phase  <= '0;
            r_outer  <= '0;
            r_inner  <= '0;
            r_addr   <= '0;
            r_emit   <= '0;
            r_drain  <= 1'b0;
            r_ovf    <= 1'b0;
            r_olim   <= '0;
            r_ilim   <= '0;
            r_nopad  <= 1'b0;
            r_pad    <= PAD_RST;
            r_div_go <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_addr   <= n_addr;
            r_emit   <= n_emit;
            r_drain  <= n_drain;
            r_ovf    <= n_ovf;
            r_olim   <= n_olim;
            r_ilim   <= n_ilim;
            r_nopad  <= n_nopad;
            r_pad    <= n_pad;
            r_div_go <= i_rows_wr;
        end
    end

    ctp_div #(
        .LW(LW),
        .RW(RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_len),
        .i_divisor  (rows_eff),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot_ceil(div_col),
        .o_rem      (div_rem)
    );

    ctp_ram #(
        .W    (BYTE_W),
        .DEPTH(MSG_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_data_byte),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(o_rd_data)
    );

    // The recount runs from the cycle after the row write until its result lands.
    assign o_busy = r_div_go || div_busy || div_done;

endmodule

`default_nettype wire

FILE: hw/rtl/columnar_transposition_engine_top.sv
// Top level of the columnar transposition engine: configuration registers, stream
// handshake, RAM read stage and output register. Uses ctp_pkg and ctp_ctrl.
// Throughput: one beat per cycle on the input, loads and pulls alike, unless a row recount
// or a stalled output holds s_axis_tready low. A pull's result passes through the RAM read
// stage into the output register. A row_count write holds s_axis_tready low while the
// one-bit-per-cycle divider recounts; synchronous active-low reset empties all and restores regs.
`default_nettype none

module columnar_transposition_engine_top
    import ctp_pkg::*;
#(
    parameter int MSG_DEPTH     = MSG_DEPTH_DEF,
    parameter int MAX_ROW_COUNT = MAX_ROW_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tuser,   // [0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,
    output logic      [OUT_USER_W-1:0] m_axis_tuser,   // [0] valid_res, [1] overflow
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    t_res              r_s1;
    logic              r_s1_v;
    logic              r_o_v;
    logic [BYTE_W-1:0] r_o_data;
    logic              r_o_last;
    logic [OUT_USER_W-1:0] r_o_user;

    logic              busy;
    logic              acc;
    logic              s1_move;
    logic              rows_wr;
    t_res              res;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] s1_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= ROWS_RST;
            r_cfg.mode <= MODE_RST;
            r_cfg.pad  <= PAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_cfg.rows <= i_cfg_data[ROW_W-1:0];
                CFG_MODE: r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                CFG_PAD:  r_cfg.pad  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign rows_wr = i_cfg_we && (i_cfg_idx == CFG_ROWS);

    // The RAM read stage moves on whenever the output register is free or drained.
    assign s1_move       = r_s1_v && (!r_o_v || m_axis_tready);
    assign s_axis_tready = !busy && (!r_s1_v || s1_move);
    assign acc           = s_axis_tvalid && s_axis_tready;

    ctp_ctrl #(
        .MSG_DEPTH    (MSG_DEPTH),
        .MAX_ROW_COUNT(MAX_ROW_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_kind     (s_axis_tuser),
        .i_data_byte(s_axis_tdata),
        .i_cfg      (r_cfg),
        .i_rows_wr  (rows_wr),
        .o_busy     (busy),
        .o_res      (res),
        .o_rd_data  (rd_data)
    );

    always_comb begin
        if (r_s1.use_pad) begin
            s1_byte = r_s1.pad;
        end else if (r_s1.valid_res) begin
            s1_byte = rd_data;
        end else begin
            s1_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (acc && res.pull) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && res.pull) begin
            r_s1 <= res;
        end
        if (s1_move) begin
            r_o_data <= s1_byte;
            r_o_last <= r_s1.last;
            r_o_user <= {r_s1.ovf, r_s1.valid_res};
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_user;

endmodule

`default_nettype wire

FILE: hw/rtl/ctp_chk.sv
// Port-level checker for the columnar transposition engine, bound to its top level.
// Uses ctp_pkg.
`default_nettype none

module ctp_chk
    import ctp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [BYTE_W-1:0]     m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

    // The output side comes out of reset empty.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present right after reset");

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // A pull on an empty message carries a zero byte and never ends a message.
    a_empty_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("empty pull carried data or last");

    // The end of a message is only marked on an emitted byte.
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("last set on a beat without a byte");

endmodule

bind columnar_transposition_engine_top ctp_chk u_ctp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
